// ===== hdl/gmst_pkg.sv =====
// Shared constants, types and helpers for the sidereal rotation block.
`default_nettype none

package gmst_pkg;

    localparam int unsigned EPOCH_DAY = 2451545;
    localparam logic [63:0] GMST_A0   = 64'd5147698101549984486;
    localparam logic [63:0] GMST_CH   = 64'd25252756545665816;
    localparam logic [63:0] GMST_C1   = 64'd50505513076466471;
    localparam logic [63:0] GMST_KQ   = 64'd263524615752795589;
    localparam logic [63:0] INV_TWO_PI = 64'h28BE60DB9391054A;
    localparam logic signed [63:0] CORDIC_GAIN = 64'sd652032874;
    localparam int unsigned MAX_STAGES = 46;

    typedef logic [1:0] quad_t;

    // Arctangent of 2^-i in Q0.64 turns, from a truncated series.
    function automatic logic [63:0] atan_entry(input int unsigned i);
        logic [63:0]  rad;
        logic [63:0]  term;
        logic [127:0] prod;
        int unsigned  k;
        rad = '0;
        if (i == 0)
        begin
            return 64'h2000_0000_0000_0000;
        end
        for (k = 0; k < 32; k++)
        begin
            if (i * (2 * k + 1) < 64)
            begin
                term = (64'd1 << (64 - i * (2 * k + 1))) / 64'(2 * k + 1);
                if (k[0])
                begin
                    rad = rad - term;
                end
                else
                begin
                    rad = rad + term;
                end
            end
        end
        prod = rad * INV_TWO_PI;
        return prod[127:64];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/gmst_eci_to_ecef_rotation.sv =====
// Top level: sidereal angle pipeline, CORDIC cell chain, rotation stage.
//
//  channel | signals                                          | handshake
//  --------+--------------------------------------------------+-----------------
//  input   | jd_whole, jd_fraction, eci_x, eci_y, eci_z       | start & !busy
//  result  | ecef_x, ecef_y, ecef_z, sidereal_angle           | done, one cycle
//
// One item per cycle; busy is tied low. Items pass in turn through the angle
// pipeline, the chain of CORDIC cells and the rotation multipliers. Reset
// clears only valid bits. Results cannot be held off; each leaves on done
// for exactly one cycle.
`default_nettype none

module gmst_eci_to_ecef_rotation
    import gmst_pkg::*;
#(
    parameter int unsigned ANGLE_BITS    = 32,
    parameter int unsigned POSITION_BITS = 32,
    parameter int unsigned CORDIC_STAGES = 30
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [21:0]        jd_whole,
    input  wire logic [31:0]        jd_fraction,
    input  wire logic signed [31:0] eci_x,
    input  wire logic signed [31:0] eci_y,
    input  wire logic signed [31:0] eci_z,
    output logic                    done,
    output logic signed [31:0]      ecef_x,
    output logic signed [31:0]      ecef_y,
    output logic signed [31:0]      ecef_z,
    output logic [31:0]             sidereal_angle
);

    localparam int unsigned PW = 32;
    localparam int unsigned N  = CORDIC_STAGES;

    logic                 v_c [N+1];
    logic signed [63:0]   x_c [N+1];
    logic signed [63:0]   y_c [N+1];
    logic [63:0]          r_c [N+1];
    quad_t                q_c [N+1];
    logic [31:0]          a_c [N+1];
    logic signed [PW-1:0] px_c [N+1];
    logic signed [PW-1:0] py_c [N+1];
    logic signed [PW-1:0] pz_c [N+1];

    assign busy = 1'b0;
    assign x_c[0] = CORDIC_GAIN;
    assign y_c[0] = '0;

    gmst_angle #(.ANGLE_BITS(ANGLE_BITS), .PW(PW)) u_angle (
        .clk(clk), .rst_n(rst_n), .vld_in(start & ~busy),
        .jd_whole(jd_whole), .jd_fraction(jd_fraction),
        .px_in(eci_x), .py_in(eci_y), .pz_in(eci_z),
        .vld_out(v_c[0]), .resid_out(r_c[0]), .quad_out(q_c[0]), .ang_out(a_c[0]),
        .px_out(px_c[0]), .py_out(py_c[0]), .pz_out(pz_c[0])
    );

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        gmst_cell #(.STAGE(g), .PW(PW)) u_cell (
            .clk(clk), .rst_n(rst_n), .vld_in(v_c[g]),
            .x_in(x_c[g]), .y_in(y_c[g]), .r_in(r_c[g]), .q_in(q_c[g]),
            .ang_in(a_c[g]), .px_in(px_c[g]), .py_in(py_c[g]), .pz_in(pz_c[g]),
            .vld_out(v_c[g+1]), .x_out(x_c[g+1]), .y_out(y_c[g+1]),
            .r_out(r_c[g+1]), .q_out(q_c[g+1]), .ang_out(a_c[g+1]),
            .px_out(px_c[g+1]), .py_out(py_c[g+1]), .pz_out(pz_c[g+1])
        );
    end

    gmst_rotate #(.POSITION_BITS(POSITION_BITS), .PW(PW)) u_rotate (
        .clk(clk), .rst_n(rst_n), .vld_in(v_c[N]),
        .x_in(x_c[N]), .y_in(y_c[N]), .q_in(q_c[N]), .ang_in(a_c[N]),
        .px_in(px_c[N]), .py_in(py_c[N]), .pz_in(pz_c[N]),
        .vld_out(done), .rx_out(ecef_x), .ry_out(ecef_y), .rz_out(ecef_z),
        .ang_out(sidereal_angle)
    );

    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !v_c[0] && !v_c[N] |=> ##2 !done || $past(v_c[N], 2))
        else $error("done without item");
    a_chain: assert property (@(posedge clk) disable iff (!rst_n)
        v_c[0] |=> v_c[1])
        else $error("item lost in chain");

endmodule

`default_nettype wire

// ===== hdl/gmst_cell.sv =====
// One CORDIC rotation cell: one micro-rotation on the vector, item data handed on.
`default_nettype none

module gmst_cell
    import gmst_pkg::*;
#(
    parameter int unsigned STAGE = 0,
    parameter int unsigned PW    = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 vld_in,
    input  wire logic signed [63:0]   x_in,
    input  wire logic signed [63:0]   y_in,
    input  wire logic [63:0]          r_in,
    input  wire quad_t                q_in,
    input  wire logic [31:0]          ang_in,
    input  wire logic signed [PW-1:0] px_in,
    input  wire logic signed [PW-1:0] py_in,
    input  wire logic signed [PW-1:0] pz_in,
    output logic                      vld_out,
    output logic signed [63:0]        x_out,
    output logic signed [63:0]        y_out,
    output logic [63:0]               r_out,
    output quad_t                     q_out,
    output logic [31:0]               ang_out,
    output logic signed [PW-1:0]      px_out,
    output logic signed [PW-1:0]      py_out,
    output logic signed [PW-1:0]      pz_out
);

    localparam logic [63:0] ATAN = atan_entry(STAGE);

    logic signed [63:0] dx;
    logic signed [63:0] dy;

    assign dx = y_in >>> STAGE;
    assign dy = x_in >>> STAGE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_out <= 1'b0;
        end
        else
        begin
            vld_out <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!r_in[63])
        begin
            x_out <= x_in - dx;
            y_out <= y_in + dy;
            r_out <= r_in - ATAN;
        end
        else
        begin
            x_out <= x_in + dx;
            y_out <= y_in - dy;
            r_out <= r_in + ATAN;
        end
        q_out   <= q_in;
        ang_out <= ang_in;
        px_out  <= px_in;
        py_out  <= py_in;
        pz_out  <= pz_in;
    end

endmodule

`default_nettype wire

// ===== hdl/gmst_angle.sv =====
// Pipelined mean sidereal angle: day, hour-of-day and t-squared terms.
`default_nettype none

module gmst_angle
    import gmst_pkg::*;
#(
    parameter int unsigned ANGLE_BITS = 32,
    parameter int unsigned PW         = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 vld_in,
    input  wire logic [21:0]          jd_whole,
    input  wire logic [31:0]          jd_fraction,
    input  wire logic signed [PW-1:0] px_in,
    input  wire logic signed [PW-1:0] py_in,
    input  wire logic signed [PW-1:0] pz_in,
    output logic                      vld_out,
    output logic [63:0]               resid_out,
    output quad_t                     quad_out,
    output logic [31:0]               ang_out,
    output logic signed [PW-1:0]      px_out,
    output logic signed [PW-1:0]      py_out,
    output logic signed [PW-1:0]      pz_out
);

    localparam int unsigned LAT = 7;
    localparam logic [63:0] HALF_LSB = 64'd1 << (63 - ANGLE_BITS);

    // stage 1
    logic [63:0]  u_reg;
    logic [63:0]  td_reg;
    logic [53:0]  mag_reg;
    // stage 2: partial products on 32-bit halves
    logic [63:0]  ch_lo_reg;
    logic [31:0]  ch_hi_reg;
    logic [63:0]  uc_reg [4];
    logic [63:0]  sq_reg [4];
    logic [63:0]  u2_reg;
    // stage 3
    logic [63:0]  ch_reg;
    logic [63:0]  uc_hi_reg;
    logic [63:0]  sq_hi_reg;
    logic [63:0]  u3_reg;
    // stage 4: K * sq partial products
    logic [63:0]  kq_reg [4];
    logic [63:0]  base_reg;
    // stage 5
    logic [63:0]  theta_reg;
    // stage 6
    logic [63:0]  ang_reg;

    logic         vld_pipe_reg [LAT];
    logic signed [PW-1:0] pxd_reg [LAT];
    logic signed [PW-1:0] pyd_reg [LAT];
    logic signed [PW-1:0] pzd_reg [LAT];

    logic [23:0]        mid_dd;
    logic signed [55:0] dd;
    logic [63:0]        m10;
    logic [63:0]        mid_uc, mid_sq, mid_kq;
    logic [63:0]        kq_hi;
    logic [63:0]        ang_r;
    quad_t              q;

    // day offset from the epoch fits 24 bits signed
    assign mid_dd = 24'(jd_whole) - 24'(EPOCH_DAY);
    assign dd     = {mid_dd, jd_fraction};
    assign m10    = {mag_reg, 10'd0};

    always_ff @(posedge clk)
    begin
        u_reg   <= {jd_fraction + 32'h8000_0000, 32'd0};
        td_reg  <= 64'(2 * (64'(jd_whole) + 64'(jd_fraction[31]))) - 64'(2 * EPOCH_DAY + 1);
        mag_reg <= dd[55] ? 54'(-dd) : 54'(dd);

        ch_lo_reg <= 64'(td_reg[31:0]) * 64'(GMST_CH[31:0]);
        ch_hi_reg <= 32'(64'(td_reg[31:0]) * 64'(GMST_CH[63:32])
                   + 64'(td_reg[63:32]) * 64'(GMST_CH[31:0]));
        uc_reg[0] <= 64'(u_reg[31:0])  * 64'(GMST_C1[31:0]);
        uc_reg[1] <= 64'(u_reg[31:0])  * 64'(GMST_C1[63:32]);
        uc_reg[2] <= 64'(u_reg[63:32]) * 64'(GMST_C1[31:0]);
        uc_reg[3] <= 64'(u_reg[63:32]) * 64'(GMST_C1[63:32]);
        sq_reg[0] <= 64'(m10[31:0])  * 64'(m10[31:0]);
        sq_reg[1] <= 64'(m10[31:0])  * 64'(m10[63:32]);
        sq_reg[2] <= 64'(m10[63:32]) * 64'(m10[31:0]);
        sq_reg[3] <= 64'(m10[63:32]) * 64'(m10[63:32]);
        u2_reg    <= u_reg;

        ch_reg    <= ch_lo_reg + {ch_hi_reg, 32'd0};
        uc_hi_reg <= uc_reg[3] + (uc_reg[1] >> 32) + (uc_reg[2] >> 32) + (mid_uc >> 32);
        sq_hi_reg <= sq_reg[3] + (sq_reg[1] >> 32) + (sq_reg[2] >> 32) + (mid_sq >> 32);
        u3_reg    <= u2_reg;

        kq_reg[0] <= 64'(sq_hi_reg[31:0])  * 64'(GMST_KQ[31:0]);
        kq_reg[1] <= 64'(sq_hi_reg[31:0])  * 64'(GMST_KQ[63:32]);
        kq_reg[2] <= 64'(sq_hi_reg[63:32]) * 64'(GMST_KQ[31:0]);
        kq_reg[3] <= 64'(sq_hi_reg[63:32]) * 64'(GMST_KQ[63:32]);
        base_reg  <= GMST_A0 + ch_reg + u3_reg + uc_hi_reg;

        theta_reg <= base_reg + kq_hi;
        ang_reg   <= ang_r;

        resid_out <= ang_reg - {q, 62'd0};
        quad_out  <= q;
        ang_out   <= ang_reg[63:32];
    end

    assign mid_uc = (uc_reg[0] >> 32) + {32'd0, uc_reg[1][31:0]} + {32'd0, uc_reg[2][31:0]};
    assign mid_sq = (sq_reg[0] >> 32) + {32'd0, sq_reg[1][31:0]} + {32'd0, sq_reg[2][31:0]};
    assign mid_kq = (kq_reg[0] >> 32) + {32'd0, kq_reg[1][31:0]} + {32'd0, kq_reg[2][31:0]};
    assign kq_hi  = kq_reg[3] + (kq_reg[1] >> 32) + (kq_reg[2] >> 32) + (mid_kq >> 32);
    assign ang_r  = ((theta_reg + HALF_LSB) >> (64 - ANGLE_BITS)) << (64 - ANGLE_BITS);
    assign q      = quad_t'((ang_reg + 64'h2000_0000_0000_0000) >> 62);

    // delay line for valid and position alongside the angle stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                vld_pipe_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_pipe_reg[0] <= vld_in;
            for (int i = 1; i < LAT; i++)
            begin
                vld_pipe_reg[i] <= vld_pipe_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pxd_reg[0] <= px_in;
        pyd_reg[0] <= py_in;
        pzd_reg[0] <= pz_in;
        for (int i = 1; i < LAT; i++)
        begin
            pxd_reg[i] <= pxd_reg[i-1];
            pyd_reg[i] <= pyd_reg[i-1];
            pzd_reg[i] <= pzd_reg[i-1];
        end
    end

    // resid/quad/ang register after ang_reg: 7 stages; valid taps to match
    assign vld_out = vld_pipe_reg[LAT-1];
    assign px_out  = pxd_reg[LAT-1];
    assign py_out  = pyd_reg[LAT-1];
    assign pz_out  = pzd_reg[LAT-1];

endmodule

`default_nettype wire

// ===== hdl/gmst_rotate.sv =====
// Quadrant map, position rotation, rounding and saturation.
`default_nettype none

module gmst_rotate
    import gmst_pkg::*;
#(
    parameter int unsigned POSITION_BITS = 32,
    parameter int unsigned PW            = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 vld_in,
    input  wire logic signed [63:0]   x_in,
    input  wire logic signed [63:0]   y_in,
    input  wire quad_t                q_in,
    input  wire logic [31:0]          ang_in,
    input  wire logic signed [PW-1:0] px_in,
    input  wire logic signed [PW-1:0] py_in,
    input  wire logic signed [PW-1:0] pz_in,
    output logic                      vld_out,
    output logic signed [31:0]        rx_out,
    output logic signed [31:0]        ry_out,
    output logic signed [31:0]        rz_out,
    output logic [31:0]               ang_out
);

    localparam int unsigned SB = (POSITION_BITS < 32) ? POSITION_BITS : 32;
    localparam logic signed [63:0] HI = (64'sd1 <<< (SB - 1)) - 64'sd1;
    localparam logic signed [63:0] LO = -HI - 64'sd1;

    // CORDIC output stays within about 2^30, so 32 bits hold cos and sin
    logic signed [31:0] c_reg, s_reg;
    logic signed [63:0] cx, sx;
    logic signed [PW-1:0] px_reg, py_reg, pz_reg, pz2_reg;
    logic signed [63:0] cx_reg, sy_reg, cy_reg, sxp_reg;
    logic signed [63:0] sum_x, sum_y;
    logic [31:0] ang1_reg, ang2_reg;
    logic [1:0]  vld_reg;

    always_comb
    begin
        case (q_in)
            2'd0:    begin cx = x_in;  sx = y_in;  end
            2'd1:    begin cx = -y_in; sx = x_in;  end
            2'd2:    begin cx = -x_in; sx = -y_in; end
            default: begin cx = y_in;  sx = -x_in; end
        endcase
    end

    function automatic logic signed [31:0] sat(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = (v > HI) ? HI : ((v < LO) ? LO : v);
        return r[31:0];
    endfunction

    always_ff @(posedge clk)
    begin
        c_reg    <= 32'(cx);
        s_reg    <= 32'(sx);
        px_reg   <= px_in;
        py_reg   <= py_in;
        pz_reg   <= pz_in;
        ang1_reg <= ang_in;

        cx_reg  <= 64'(c_reg) * 64'(px_reg);
        sy_reg  <= 64'(s_reg) * 64'(py_reg);
        cy_reg  <= 64'(c_reg) * 64'(py_reg);
        sxp_reg <= 64'(s_reg) * 64'(px_reg);
        pz2_reg <= pz_reg;
        ang2_reg <= ang1_reg;

        rx_out  <= sat(sum_x >>> 30);
        ry_out  <= sat(sum_y >>> 30);
        rz_out  <= sat(64'(pz2_reg));
        ang_out <= ang2_reg;
    end

    assign sum_x = cx_reg + sy_reg + 64'sd536870912;
    assign sum_y = cy_reg - sxp_reg + 64'sd536870912;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            vld_out <= 1'b0;
        end
        else
        begin
            vld_reg <= {vld_reg[0], vld_in};
            vld_out <= vld_reg[1];
        end
    end

endmodule

`default_nettype wire
